// ===== hdl/rrt_pkg.sv =====
// rrt_pkg: shared types, command codes and sizes for the range remap table
// used by every module of the block; depends on nothing
`default_nettype none

package rrt_pkg;

   localparam int VALUE_BITS  = 31;
   localparam int WINDOWS     = 32;
   localparam int CMD_BITS    = 2;
   localparam int ENTRY_BITS  = 6;

   // command codes
   localparam logic [CMD_BITS-1:0] CMD_APPEND = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_CLEAR  = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_XLATE  = 2'd2;
   localparam logic [CMD_BITS-1:0] CMD_NOP    = 2'd3;

   // status codes
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef struct packed {
      logic [CMD_BITS-1:0]   cmd;
      logic [VALUE_BITS-1:0] dest_start;
      logic [VALUE_BITS-1:0] src_start;
      logic [VALUE_BITS-1:0] span_length;
      logic [VALUE_BITS-1:0] lookup_value;
   } req_type;

   typedef struct packed {
      logic [VALUE_BITS-1:0] mapped_value;
      logic                  hit;
      logic [ENTRY_BITS-1:0] entries_used;
      logic                  status;
   } rsp_type;

   // one stored window
   typedef struct packed {
      logic [VALUE_BITS-1:0] dest;
      logic [VALUE_BITS-1:0] src;
      logic [VALUE_BITS-1:0] len;
   } window_type;

   // window write broadcast to the cells
   typedef struct packed {
      logic       valid;
      window_type window;
   } win_wr_type;

   // lookup token handed from cell to cell
   typedef struct packed {
      logic                  valid;
      logic [VALUE_BITS-1:0] value;
      logic                  hit;
      logic [VALUE_BITS-1:0] mapped;
   } token_type;

endpackage

`default_nettype wire

// ===== hdl/rrt_cell.sv =====
// rrt_cell: one window slot of the remap chain, checks the passing lookup token
// depends on rrt_pkg
`default_nettype none

module rrt_cell
   import rrt_pkg::*;
#(
   parameter int CELL_INDEX = 0,
   parameter int COUNT_BITS = 6
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [COUNT_BITS-1:0] count,
   input  wire win_wr_type            win_wr,
   input  wire token_type             tok_in,
   output      token_type             tok_out
);

   window_type            win_ff;
   logic                  tok_valid_ff;
   logic                  tok_valid_in;
   logic [VALUE_BITS-1:0] tok_value_ff;
   logic                  tok_hit_ff;
   logic                  tok_hit_in;
   logic [VALUE_BITS-1:0] tok_mapped_ff;
   logic [VALUE_BITS-1:0] tok_mapped_in;

   logic [VALUE_BITS:0]   diff;
   logic                  active;
   logic                  in_span;
   logic                  match;

   // slot is live only below the fill count
   assign active  = COUNT_BITS'(CELL_INDEX) < count;
   assign diff    = {1'b0, tok_in.value} - {1'b0, win_ff.src};
   assign in_span = !diff[VALUE_BITS] && (diff[VALUE_BITS-1:0] < win_ff.len);
   assign match   = tok_in.valid && !tok_in.hit && active && in_span;

   assign tok_valid_in  = tok_in.valid;
   assign tok_hit_in    = tok_in.hit || match;
   assign tok_mapped_in = match ? (diff[VALUE_BITS-1:0] + win_ff.dest) : tok_in.mapped;

   always_ff @(posedge clock) begin
      if (win_wr.valid && (count == COUNT_BITS'(CELL_INDEX))) begin
         win_ff <= win_wr.window;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_valid_ff <= 1'b0;
      end else begin
         tok_valid_ff <= tok_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tok_value_ff  <= tok_in.value;
      tok_hit_ff    <= tok_hit_in;
      tok_mapped_ff <= tok_mapped_in;
   end

   assign tok_out.valid  = tok_valid_ff;
   assign tok_out.value  = tok_value_ff;
   assign tok_out.hit    = tok_hit_ff;
   assign tok_out.mapped = tok_mapped_ff;

endmodule

`default_nettype wire

// ===== hdl/range_remap_table_core.sv =====
// range_remap_table_core: top level, fill count, command decode and response register
// depends on rrt_pkg and rrt_cell
`default_nettype none

// Range remap table. Holds up to WINDOWS windows (source start, destination
// start, length), one per cell of a chain. Issue a beat with start while busy
// is low. For append, clear and no-op beats the response strobe comes in the
// cycle after the beat and busy stays low. A translate beat sends a lookup
// token down the chain, one cell per cycle; busy stays high while the token is
// in the chain, and the response strobe follows once the token reaches the
// chain tail and passes the response register. The first loaded window whose
// half-open span holds the value wins. Every beat gives exactly one response,
// held on rsp_data for a single cycle under rsp_strobe; the receiver cannot
// stall, so capture it then. An append into a full table is dropped with
// status full. No clearing pass after reset: the fill count alone decides
// which cells take part in a lookup.

module range_remap_table_core
   import rrt_pkg::*;
#(
   parameter int WINDOWS = rrt_pkg::WINDOWS
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output      logic    busy,
   input  wire req_type req_data,
   output      logic    rsp_strobe,
   output      rsp_type rsp_data
);

   localparam int COUNT_BITS = $clog2(WINDOWS + 1);

   // fill count of the table
   logic [COUNT_BITS-1:0] count_ff;
   logic [COUNT_BITS-1:0] count_in;

   // response register
   logic    strobe_ff;
   logic    strobe_in;
   rsp_type rsp_ff;
   rsp_type rsp_in;

   logic       accept;
   logic       not_full;
   win_wr_type win_wr;

   // chain links: link[0] feeds cell 0, link[WINDOWS] is the chain tail
   token_type              link [WINDOWS+1];
   logic [WINDOWS-1:0]     chain_valid;

   assign accept   = start && !busy;
   assign not_full = count_ff < COUNT_BITS'(WINDOWS);

   // busy while a lookup token is anywhere in the chain
   assign busy = |chain_valid;

   // append goes into the cell whose index equals the fill count
   assign win_wr.valid       = accept && (req_data.cmd == CMD_APPEND) && not_full;
   assign win_wr.window.dest = req_data.dest_start;
   assign win_wr.window.src  = req_data.src_start;
   assign win_wr.window.len  = req_data.span_length;

   // new lookup token enters the head of the chain
   assign link[0].valid  = accept && (req_data.cmd == CMD_XLATE);
   assign link[0].value  = req_data.lookup_value;
   assign link[0].hit    = 1'b0;
   assign link[0].mapped = req_data.lookup_value;

   for (genvar i = 0; i < WINDOWS; i++) begin : g_cell
      rrt_cell #(
         .CELL_INDEX (i),
         .COUNT_BITS (COUNT_BITS)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .count   (count_ff),
         .win_wr  (win_wr),
         .tok_in  (link[i]),
         .tok_out (link[i+1])
      );
      assign chain_valid[i] = link[i+1].valid;
   end

   // command decode and response assembly
   always_comb begin
      count_in            = count_ff;
      strobe_in           = 1'b0;
      rsp_in.mapped_value = '0;
      rsp_in.hit          = 1'b0;
      rsp_in.status       = STATUS_OK;
      if (link[WINDOWS].valid) begin
         // lookup done at the tail; no beat can be taken in this cycle
         strobe_in           = 1'b1;
         rsp_in.mapped_value = link[WINDOWS].mapped;
         rsp_in.hit          = link[WINDOWS].hit;
      end else if (accept) begin
         unique case (req_data.cmd)
            CMD_APPEND: begin
               strobe_in = 1'b1;
               if (not_full) begin
                  count_in = count_ff + COUNT_BITS'(1);
               end else begin
                  rsp_in.status = STATUS_FULL;
               end
            end
            CMD_CLEAR: begin
               strobe_in = 1'b1;
               count_in  = '0;
            end
            CMD_NOP: begin
               strobe_in = 1'b1;
            end
            CMD_XLATE: begin
               // response comes from the chain tail
               strobe_in = 1'b0;
            end
            default: begin
               strobe_in = 1'b0;
            end
         endcase
      end
      // count after this beat
      rsp_in.entries_used = ENTRY_BITS'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

`default_nettype wire

// ===== hdl/rrt_checker.sv =====
// rrt_checker: port-level assertions for range_remap_table_core, with its bind
// depends on rrt_pkg and range_remap_table_core
`default_nettype none

module rrt_checker
   import rrt_pkg::*;
#(
   parameter int WINDOWS = rrt_pkg::WINDOWS
) (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    start,
   input wire logic    busy,
   input wire req_type req_data,
   input wire logic    rsp_strobe,
   input wire rsp_type rsp_data
);

   logic accept;

   assign accept = start && !busy;

   // short commands answer in the next cycle
   a_short_rsp: assert property (@(posedge clock) disable iff (reset)
      accept && (req_data.cmd != CMD_XLATE) |=> rsp_strobe)
      else $error("no response after a short beat");

   // a lookup holds the block busy
   a_xlate_busy: assert property (@(posedge clock) disable iff (reset)
      accept && (req_data.cmd == CMD_XLATE) |=> busy && !rsp_strobe)
      else $error("lookup beat did not raise busy");

   // clear empties the table
   a_clear: assert property (@(posedge clock) disable iff (reset)
      accept && (req_data.cmd == CMD_CLEAR)
      |=> rsp_strobe && (rsp_data.entries_used == '0) && !rsp_data.hit)
      else $error("clear response wrong");

   // a dropped append reports a full table
   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_data.status == STATUS_FULL)
      |-> (rsp_data.entries_used == ENTRY_BITS'(WINDOWS)) && !rsp_data.hit)
      else $error("full status with a table that is not full");

   // a hit never comes with a full status
   a_hit_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.hit |-> (rsp_data.status == STATUS_OK))
      else $error("hit reported with full status");

endmodule

bind range_remap_table_core rrt_checker #(
   .WINDOWS (WINDOWS)
) u_rrt_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_data   (req_data),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

`default_nettype wire
